@@ hdl/blng_pkg.sv @@
// Package for the bilayer lattice neighbor generator.
// Holds field widths, the neighbor kind codes and the word structs.
// No dependencies.
`timescale 1ns / 1ps

package blng_pkg;

  localparam int IdxW       = 14;
  localparam int KindW      = 2;
  localparam int CfgW       = 7;
  localparam int MaxSideDef = 64;
  localparam int SideRst    = 4;
  localparam int SideMin    = 2;

  localparam logic [1:0] LastSlot = 2'd3;

  typedef enum logic [KindW-1:0] {
    KIND_NEAREST  = 2'd0,
    KIND_DIAGONAL = 2'd1,
    KIND_OPPOSITE = 2'd2,
    KIND_INVALID  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [IdxW-1:0]  site_index;
    logic [KindW-1:0] neighbor_kind;
  } in_word_t;

  typedef struct packed {
    logic [IdxW-1:0] neighbor_index;
    logic            last_neighbor;
    logic            bad_request;
  } out_word_t;

  // travels alongside the remainder pipeline
  typedef struct packed {
    logic [IdxW-1:0]  site;
    logic [KindW-1:0] kind;
    logic             bad;
    logic             upper;
    logic [IdxW-1:0]  base;
    logic [IdxW-1:0]  inplane;
  } carry_t;

endpackage

@@ hdl/blng_rem.sv @@
// Pipelined restoring remainder unit: in-plane offset mod side length.
// Two quotient bits per stage; sideband carried alongside.
// Depends on blng_pkg.
`timescale 1ns / 1ps

module blng_rem #(
  parameter int MAX_SIDE = blng_pkg::MaxSideDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [blng_pkg::IdxW-1:0]        dividend_i,
  input  logic [$clog2(MAX_SIDE+1)-1:0]    divisor_i,
  input  blng_pkg::carry_t                 carry_i,
  output logic                             valid_o,
  output logic [$clog2(MAX_SIDE+1)-1:0]    rem_o,
  output blng_pkg::carry_t                 carry_o
);

  localparam int IW  = blng_pkg::IdxW;
  localparam int SW  = $clog2(MAX_SIDE + 1);
  localparam int QW  = $clog2(MAX_SIDE);
  localparam int NST = (QW + 1) / 2;
  localparam int CW  = IW + SW;

  logic [NST-1:0]   v_q;
  logic [CW-1:0]    rem_q [NST];
  blng_pkg::carry_t car_q [NST];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    localparam int I0  = QW - 1 - 2 * k;
    localparam int I1  = I0 - 1;
    localparam int Sh1 = (I1 < 0) ? 0 : I1;

    logic             v_in;
    logic [CW-1:0]    r_in;
    logic [CW-1:0]    r_d;
    blng_pkg::carry_t c_in;

    if (k == 0) begin : g_first
      assign v_in = valid_i;
      assign r_in = CW'(dividend_i);
      assign c_in = carry_i;
    end else begin : g_next
      assign v_in = v_q[k-1];
      assign r_in = rem_q[k-1];
      assign c_in = car_q[k-1];
    end

    always_comb begin
      r_d = r_in;
      if (r_d >= (CW'(divisor_i) << I0)) begin
        r_d = r_d - (CW'(divisor_i) << I0);
      end
      if ((I1 >= 0) && (r_d >= (CW'(divisor_i) << Sh1))) begin
        r_d = r_d - (CW'(divisor_i) << Sh1);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= r_d;
        car_q[k] <= c_in;
      end
    end
  end

  assign valid_o = v_q[NST-1];
  assign rem_o   = rem_q[NST-1][SW-1:0];
  assign carry_o = car_q[NST-1];

endmodule

@@ hdl/bilayer_lattice_neighbor_gen.sv @@
// Top level: neighbor index generator for a two-layer periodic square lattice.
// Instantiates blng_rem; uses blng_pkg.
//
//   port group   dir   payload        handshake
//   in_*         in    in_word_t      in_valid_i / in_ready_o
//   out_*        out   out_word_t     out_valid_o / out_ready_i
//   cfg_*        in    side length    cfg_we_i, no wait
//
// A word passes input capture, plane select, the remainder stages and the hold
// stage. One result word per cycle while the receiver is ready: nearest and
// diagonal words give four results, opposite and rejected words one. The hold
// stage keeps a word until its final result enters the output register; all
// earlier stages advance together when it frees, so a stall drops nothing.
// Reset clears valid bits and sets side length to 4.
`timescale 1ns / 1ps

module bilayer_lattice_neighbor_gen #(
  parameter int MAX_SIDE = blng_pkg::MaxSideDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  blng_pkg::in_word_t        in_word_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output blng_pkg::out_word_t       out_word_o,
  input  logic                      cfg_we_i,
  input  logic [blng_pkg::CfgW-1:0] cfg_wdata_i
);

  localparam int IW      = blng_pkg::IdxW;
  localparam int KW      = blng_pkg::KindW;
  localparam int SW      = $clog2(MAX_SIDE + 1);
  localparam int SSW     = 2 * SW;
  localparam int EW      = SSW + 2;
  localparam int SideRst = (MAX_SIDE < blng_pkg::SideRst) ? MAX_SIDE : blng_pkg::SideRst;

  // configuration
  logic [SW-1:0]  side_q, side_d;
  logic [SSW-1:0] ss_q, ss_d;

  always_comb begin
    if (int'(cfg_wdata_i) < blng_pkg::SideMin) begin
      side_d = SW'(blng_pkg::SideMin);
    end else if (int'(cfg_wdata_i) > MAX_SIDE) begin
      side_d = SW'(MAX_SIDE);
    end else begin
      side_d = SW'(cfg_wdata_i);
    end
    ss_d = SSW'(side_d) * SSW'(side_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SW'(SideRst);
      ss_q   <= SSW'(SideRst * SideRst);
    end else if (cfg_we_i) begin
      side_q <= side_d;
      ss_q   <= ss_d;
    end
  end

  // pipeline control
  logic en;
  logic out_fire;
  logic h_last;
  logic h_v_q;
  logic out_v_q;

  assign en         = !h_v_q || (out_fire && h_last);
  assign in_ready_o = en;

  // stage 1: input capture
  logic          p1_v_q;
  logic [IW-1:0] p1_site_q;
  logic [KW-1:0] p1_kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (en) begin
      p1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_site_q <= in_word_i.site_index;
      p1_kind_q <= in_word_i.neighbor_kind;
    end
  end

  // stage 2: plane select
  logic [EW-1:0]    site_e, ss1, ss2, ss3, ss4;
  logic             ge1, ge2, ge3, ge4;
  blng_pkg::carry_t p2_d, p2_q;
  logic             p2_v_q;

  always_comb begin
    site_e = EW'(p1_site_q);
    ss1    = EW'(ss_q);
    ss2    = ss1 << 1;
    ss3    = ss1 + ss2;
    ss4    = ss1 << 2;
    ge1    = site_e >= ss1;
    ge2    = site_e >= ss2;
    ge3    = site_e >= ss3;
    ge4    = site_e >= ss4;
    p2_d.site = p1_site_q;
    p2_d.kind = p1_kind_q;
    p2_d.bad  = ge4 || (p1_kind_q == blng_pkg::KIND_INVALID);
    if (ge3) begin
      p2_d.base  = IW'(ss3);
      p2_d.upper = 1'b1;
    end else if (ge2) begin
      p2_d.base  = IW'(ss2);
      p2_d.upper = 1'b0;
    end else if (ge1) begin
      p2_d.base  = IW'(ss1);
      p2_d.upper = 1'b1;
    end else begin
      p2_d.base  = '0;
      p2_d.upper = 1'b0;
    end
    p2_d.inplane = p1_site_q - p2_d.base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
    end else if (en) begin
      p2_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_q <= p2_d;
    end
  end

  // column via pipelined remainder
  logic             rm_v;
  logic [SW-1:0]    rm_x;
  blng_pkg::carry_t rm_c;

  blng_rem #(
    .MAX_SIDE (MAX_SIDE)
  ) u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (p2_v_q),
    .dividend_i (p2_q.inplane),
    .divisor_i  (side_q),
    .carry_i    (p2_q),
    .valid_o    (rm_v),
    .rem_o      (rm_x),
    .carry_o    (rm_c)
  );

  // row bases and wrapped columns
  logic [IW-1:0] side_w, ss_w, ys;
  logic          ylow, yhigh;
  logic [IW-1:0] rowm_d, row0_d, rowp_d, opp_d;
  logic [SW-1:0] xm_d, xp_d;

  always_comb begin
    side_w = IW'(side_q);
    ss_w   = IW'(ss_q);
    ys     = rm_c.inplane - IW'(rm_x);
    ylow   = EW'(rm_c.inplane) < EW'(side_q);
    yhigh  = EW'(rm_c.inplane) >= (EW'(ss_q) - EW'(side_q));
    row0_d = rm_c.base + ys;
    rowm_d = rm_c.base + (ylow ? (ss_w - side_w) : (ys - side_w));
    rowp_d = rm_c.base + (yhigh ? '0 : (ys + side_w));
    xm_d   = (rm_x == '0) ? (side_q - 1'b1) : (rm_x - 1'b1);
    xp_d   = (rm_x == (side_q - 1'b1)) ? '0 : (rm_x + 1'b1);
    opp_d  = rm_c.upper ? (rm_c.site - ss_w) : (rm_c.site + ss_w);
  end

  // hold stage: emits up to four results
  logic [KW-1:0] h_kind_q;
  logic          h_bad_q;
  logic [IW-1:0] h_rowm_q, h_row0_q, h_rowp_q, h_opp_q;
  logic [SW-1:0] h_xm_q, h_x_q, h_xp_q;
  logic [1:0]    cnt_q;
  logic          h_single;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_v_q <= 1'b0;
    end else if (en) begin
      h_v_q <= rm_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_kind_q <= rm_c.kind;
      h_bad_q  <= rm_c.bad;
      h_rowm_q <= rowm_d;
      h_row0_q <= row0_d;
      h_rowp_q <= rowp_d;
      h_opp_q  <= opp_d;
      h_xm_q   <= xm_d;
      h_x_q    <= rm_x;
      h_xp_q   <= xp_d;
    end
  end

  assign h_single = h_bad_q || (h_kind_q == blng_pkg::KIND_OPPOSITE);
  assign h_last   = h_single || (cnt_q == blng_pkg::LastSlot);
  assign out_fire = h_v_q && (!out_v_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (out_fire) begin
      cnt_q <= h_last ? '0 : (cnt_q + 1'b1);
    end
  end

  logic [IW-1:0]       row;
  logic [SW-1:0]       col;
  blng_pkg::out_word_t out_d, out_q;

  always_comb begin
    row = h_row0_q;
    col = h_x_q;
    if (h_kind_q == blng_pkg::KIND_DIAGONAL) begin
      case (cnt_q)
        2'd0: begin row = h_rowm_q; col = h_xm_q; end
        2'd1: begin row = h_rowm_q; col = h_xp_q; end
        2'd2: begin row = h_rowp_q; col = h_xp_q; end
        default: begin row = h_rowp_q; col = h_xm_q; end
      endcase
    end else begin
      case (cnt_q)
        2'd0: begin row = h_row0_q; col = h_xm_q; end
        2'd1: begin row = h_row0_q; col = h_xp_q; end
        2'd2: begin row = h_rowm_q; col = h_x_q; end
        default: begin row = h_rowp_q; col = h_x_q; end
      endcase
    end
    out_d.last_neighbor = h_last;
    out_d.bad_request   = h_bad_q;
    if (h_bad_q) begin
      out_d.neighbor_index = '0;
    end else if (h_kind_q == blng_pkg::KIND_OPPOSITE) begin
      out_d.neighbor_index = h_opp_q;
    end else begin
      out_d.neighbor_index = row + IW'(col);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_fire) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_word_o  = out_q;

  // checks
  a_count_multi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (h_v_q && (cnt_q != 2'd0)) |-> !h_single)
    else $error("result count advanced on a single-result word");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.bad_request) |-> ((out_q.neighbor_index == '0) && out_q.last_neighbor))
    else $error("rejected word with nonzero index or not last");

  a_side_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(side_q) >= blng_pkg::SideMin) && (int'(side_q) <= MAX_SIDE))
    else $error("side length out of range");

  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (h_v_q && !out_fire) |=> $stable(cnt_q))
    else $error("result count moved during stall");

  a_hold_until_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (h_v_q && !(out_fire && h_last)) |-> !en)
    else $error("pipeline advanced before last result left");

endmodule

@@ tb/tb_bilayer_lattice_neighbor_gen.sv @@
// Testbench for bilayer_lattice_neighbor_gen: neighbor queries on a periodic
// two-layer lattice over several side lengths, checked word by word.
// Depends on blng_pkg and the block's top level; self-contained otherwise.
`timescale 1ns / 1ps

module tb_bilayer_lattice_neighbor_gen;

  localparam int unsigned MaxSide   = blng_pkg::MaxSideDef;
  localparam int unsigned StallMax  = 1000;
  localparam int unsigned PhaseLen  = 19;
  localparam int unsigned NumPhases = 10;

  class neighbor_board;
    blng_pkg::out_word_t pending_neighbors[$];
    int unsigned         errors;
    int unsigned         queries;
    int unsigned         results;

    function void push_neighbor(int unsigned idx, bit last, bit bad);
      blng_pkg::out_word_t w;
      w.neighbor_index = blng_pkg::IdxW'(idx);
      w.last_neighbor  = last;
      w.bad_request    = bad;
      pending_neighbors.insert(pending_neighbors.size(), w);
    endfunction

    // expected neighbor words for one accepted query at side length s
    function void note_query(blng_pkg::in_word_t q, int unsigned s);
      int unsigned     l, area, inplane, base, x, y;
      int unsigned     dx[4], dy[4];
      blng_pkg::kind_e k;
      l    = q.site_index;
      area = s * s;
      k    = blng_pkg::kind_e'(q.neighbor_kind);
      queries++;
      if (l >= 4 * area || k == blng_pkg::KIND_INVALID) begin
        push_neighbor(0, 1'b1, 1'b1);
        return;
      end
      inplane = l % area;
      base    = l - inplane;
      x       = l % s;
      y       = inplane / s;
      case (k)
        blng_pkg::KIND_NEAREST: begin
          dx = '{s - 1, 1, 0, 0};
          dy = '{0, 0, s - 1, 1};
        end
        blng_pkg::KIND_DIAGONAL: begin
          dx = '{s - 1, 1, 1, s - 1};
          dy = '{s - 1, s - 1, 1, 1};
        end
        default: begin
          if ((l % (2 * area)) / area == 0) begin
            push_neighbor(l + area, 1'b1, 1'b0);
          end else begin
            push_neighbor(l - area, 1'b1, 1'b0);
          end
          return;
        end
      endcase
      for (int i = 0; i < 4; i++) begin
        push_neighbor(base + ((y + dy[i]) % s) * s + (x + dx[i]) % s, i == 3, 1'b0);
      end
    endfunction

    function void check_neighbor(blng_pkg::out_word_t got);
      blng_pkg::out_word_t want;
      results++;
      if (pending_neighbors.size() == 0) begin
        $error("unexpected word: neighbor_index %0d", got.neighbor_index);
        errors++;
        return;
      end
      want = pending_neighbors.pop_front();
      if (got.neighbor_index !== want.neighbor_index) begin
        $error("neighbor_index: expected %0d, got %0d", want.neighbor_index,
               got.neighbor_index);
        errors++;
      end
      if (got.last_neighbor !== want.last_neighbor) begin
        $error("last_neighbor: expected %0b, got %0b", want.last_neighbor,
               got.last_neighbor);
        errors++;
      end
      if (got.bad_request !== want.bad_request) begin
        $error("bad_request: expected %0b, got %0b", want.bad_request,
               got.bad_request);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_neighbors.size();
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  blng_pkg::in_word_t        in_word_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  blng_pkg::out_word_t       out_word_o;
  logic                      cfg_we_i;
  logic [blng_pkg::CfgW-1:0] cfg_wdata_i;

  neighbor_board board = new();
  int unsigned   cur_side;
  int unsigned   src_idle_pct;
  int unsigned   snk_stall_pct;
  int unsigned   quiet_cycles;

  bilayer_lattice_neighbor_gen i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i = ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_neighbor(out_word_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallMax) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // called at a falling edge; leaves valid high for a back-to-back word
  task automatic send_query(int unsigned site, blng_pkg::kind_e kind);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_word_i.site_index    = blng_pkg::IdxW'(site);
    in_word_i.neighbor_kind = kind;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_query(in_word_i, cur_side);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    while (board.outstanding() != 0) @(negedge clk_i);
  endtask

  task automatic set_side(logic [blng_pkg::CfgW-1:0] v);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cur_side = (v < blng_pkg::SideMin) ? blng_pkg::SideMin : (v > MaxSide) ? MaxSide : v;
  endtask

  task automatic send_random(int unsigned s);
    int unsigned roll, top;
    roll = $urandom_range(99);
    top  = 4 * s * s - 1;
    if (roll < 85) begin
      send_query($urandom_range(top), blng_pkg::kind_e'($urandom_range(2)));
    end else if (roll < 93) begin
      send_query($urandom_range(16383), blng_pkg::KIND_INVALID);
    end else if (top < 16383) begin
      send_query($urandom_range(16383, top + 1), blng_pkg::kind_e'($urandom_range(3)));
    end else begin
      send_query($urandom_range(16383), blng_pkg::kind_e'($urandom_range(3)));
    end
  endtask

  initial begin
    logic [blng_pkg::CfgW-1:0] sides[NumPhases];
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_word_i     = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    cur_side      = blng_pkg::SideRst;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    quiet_cycles  = 0;
    sides = '{7'd2, 7'd64, 7'd0, 7'd127, 7'd3, 7'd65, 7'd1, 7'd17, 7'd5,
              blng_pkg::CfgW'($urandom_range(2, 64))};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // side 4: corners, wrap, layer flips, range edge, rejects
    send_query(0, blng_pkg::KIND_NEAREST);
    send_query(0, blng_pkg::KIND_DIAGONAL);
    send_query(0, blng_pkg::KIND_OPPOSITE);
    send_query(15, blng_pkg::KIND_NEAREST);
    send_query(15, blng_pkg::KIND_DIAGONAL);
    send_query(3, blng_pkg::KIND_NEAREST);
    send_query(12, blng_pkg::KIND_DIAGONAL);
    send_query(16, blng_pkg::KIND_OPPOSITE);
    send_query(31, blng_pkg::KIND_OPPOSITE);
    send_query(40, blng_pkg::KIND_OPPOSITE);
    send_query(48, blng_pkg::KIND_OPPOSITE);
    send_query(63, blng_pkg::KIND_NEAREST);
    send_query(63, blng_pkg::KIND_DIAGONAL);
    send_query(63, blng_pkg::KIND_OPPOSITE);
    send_query(64, blng_pkg::KIND_NEAREST);
    send_query(64, blng_pkg::KIND_OPPOSITE);
    send_query(16383, blng_pkg::KIND_NEAREST);
    send_query(5, blng_pkg::KIND_INVALID);
    send_query(16383, blng_pkg::KIND_INVALID);
    send_query(21, blng_pkg::KIND_NEAREST);
    drain();

    for (int p = 0; p < NumPhases; p++) begin
      set_side(sides[p]);
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 72; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 72; end
        default: begin src_idle_pct = 12; snk_stall_pct = 12; end
      endcase
      send_query(0, blng_pkg::KIND_NEAREST);
      send_query(4 * cur_side * cur_side - 1, blng_pkg::KIND_DIAGONAL);
      for (int n = 2; n < PhaseLen; n++) begin
        if ($urandom_range(29) == 0) drain();
        send_random(cur_side);
      end
      drain();
    end

    snk_stall_pct = 0;
    repeat (20) @(posedge clk_i);
    $display("Covered %0d queries and %0d neighbor words over %0d side lengths,",
             board.queries, board.results, NumPhases + 1);
    $display("with sender gaps and receiver stalls mixed across phases.");
    if (board.outstanding() != 0) begin
      $error("%0d expected words never arrived", board.outstanding());
    end
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
